// ===== design/rcfd_pkg.sv =====
`default_nettype none

package rcfd_pkg;

   typedef logic [10:0]        chan_type;
   typedef logic signed [10:0] axis_type;
   typedef logic [4:0]         src_type;
   typedef logic [1:0]         sw_type;

   localparam int NumAxes    = 5;
   localparam int NumSwitches = 2;
   localparam int NumSrc     = NumAxes + NumSwitches;
   localparam int NumChannels = 16;

   // channel picked when a source register holds 16 or more
   localparam logic [NumSrc-1:0][3:0] DefaultChannel =
      {4'd5, 4'd4, 4'd6, 4'd3, 4'd2, 4'd1, 4'd0};
   localparam src_type SrcReset = 5'd16;

   localparam logic [7:0] CrcPoly      = 8'hD5;
   localparam logic [7:0] KindRcPacked = 8'h16;
   localparam logic [6:0] RcFrameTotal = 7'd26;

   localparam chan_type ChMin  = 11'd172;
   localparam chan_type ChMid  = 11'd992;
   localparam chan_type ChMax  = 11'd1811;
   localparam chan_type SwLow  = 11'd582;
   localparam chan_type SwHigh = 11'd1401;

   localparam int DenPos = 819;
   localparam int DenNeg = 820;
   localparam int RndPos = DenPos / 2;
   localparam int RndNeg = DenNeg / 2;
   // numerator limits where the axis saturates
   localparam int SatPos = 1024 * DenPos;
   localparam int SatNeg = 1025 * DenNeg;
   localparam int RecipShift = 30;
   localparam logic [20:0] MulPos =
      21'(((longint'(1) << RecipShift) + DenPos - 1) / DenPos);
   localparam logic [20:0] MulNeg =
      21'(((longint'(1) << RecipShift) + DenNeg - 1) / DenNeg);

   localparam axis_type AxisMax = 11'sd1023;
   localparam axis_type AxisMin = -11'sd1024;

   localparam sw_type SwDown   = 2'd0;
   localparam sw_type SwMiddle = 2'd1;
   localparam sw_type SwUp     = 2'd2;

   typedef struct packed {
      chan_type [NumAxes-1:0]     axis;
      chan_type [NumSwitches-1:0] sw;
   } pick_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/rcfd_parser.sv =====
`default_nettype none

module rcfd_parser
   import rcfd_pkg::*;
#(
   parameter int MAX_FRAME_LENGTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 byte_accept,
   input  wire logic [7:0]           byte_data,
   input  wire src_type [NumSrc-1:0] source,
   output logic                      hit,
   output pick_type                  pick
);

   localparam logic [7:0] MaxLen   = 8'(MAX_FRAME_LENGTH);
   localparam logic [7:0] MaxTotal = 8'(MAX_FRAME_LENGTH + 2);
   localparam logic [7:0] MinLen   = 8'd2;
   localparam logic [7:0] MinTotal = 8'd4;
   localparam logic [6:0] AddrPos  = 7'd0;
   localparam logic [6:0] LenPos   = 7'd1;
   localparam logic [6:0] KindPos  = 7'd2;
   localparam logic [6:0] PayloadLastPos = 7'd24;

   logic [6:0]  pos_ff, pos_in;
   logic [6:0]  total_ff, total_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  kind_ff, kind_in;
   logic [17:0] acc_ff, acc_in;
   logic [4:0]  bcnt_ff, bcnt_in;
   logic [4:0]  ccnt_ff, ccnt_in;
   chan_type    chan_ff [NumChannels];

   logic        chan_we;
   logic [17:0] shifted;
   logic [17:0] acc_or;
   logic [5:0]  bsum;
   chan_type    sel [NumSrc];

   assign shifted = 18'(byte_data) << bcnt_ff[3:0];
   assign acc_or  = acc_ff | shifted;
   assign bsum    = {1'b0, bcnt_ff} + 6'd8;

   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      crc_in   = crc_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      bcnt_in  = bcnt_ff;
      ccnt_in  = ccnt_ff;
      chan_we  = 1'b0;
      hit      = 1'b0;
      if (byte_accept) begin
         if (pos_ff == AddrPos) begin
            pos_in = LenPos;
         end else if (pos_ff == LenPos) begin
            if (byte_data < MinLen || byte_data > MaxLen) begin
               pos_in   = AddrPos;
               total_in = '0;
            end else begin
               total_in = 7'(byte_data + 8'd2);
               pos_in   = KindPos;
               crc_in   = '0;
               acc_in   = '0;
               bcnt_in  = '0;
               ccnt_in  = '0;
            end
         end else if ({1'b0, total_ff} < MinTotal || {1'b0, total_ff} > MaxTotal) begin
            pos_in   = AddrPos;
            total_in = '0;
         end else begin
            pos_in = pos_ff + 7'd1;
            if (({1'b0, pos_ff} + 8'd1) >= {1'b0, total_ff}) begin
               // last word of the frame carries the CRC
               hit = (byte_data == crc_ff) && (kind_ff == KindRcPacked) &&
                     (total_ff == RcFrameTotal) && ccnt_ff[4];
               pos_in   = AddrPos;
               total_in = '0;
            end else begin
               crc_in = crc_step(crc_ff, byte_data);
               if (pos_ff == KindPos) begin
                  kind_in = byte_data;
               end else if (pos_ff <= PayloadLastPos) begin
                  if (bsum >= 6'd11 && !ccnt_ff[4]) begin
                     chan_we = 1'b1;
                     ccnt_in = ccnt_ff + 5'd1;
                     acc_in  = acc_or >> 11;
                     bcnt_in = 5'(bsum - 6'd11);
                  end else begin
                     acc_in  = acc_or;
                     bcnt_in = bsum[4:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
         crc_ff   <= '0;
         kind_ff  <= '0;
         acc_ff   <= '0;
         bcnt_ff  <= '0;
         ccnt_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
         crc_ff   <= crc_in;
         kind_ff  <= kind_in;
         acc_ff   <= acc_in;
         bcnt_ff  <= bcnt_in;
         ccnt_ff  <= ccnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chan_we) begin
         chan_ff[ccnt_ff[3:0]] <= acc_or[10:0];
      end
   end

   always_comb begin
      for (int k = 0; k < NumSrc; k++) begin
         sel[k] = source[k][4] ? chan_ff[DefaultChannel[k]] : chan_ff[source[k][3:0]];
      end
      for (int k = 0; k < NumAxes; k++) begin
         pick.axis[k] = sel[k];
      end
      for (int k = 0; k < NumSwitches; k++) begin
         pick.sw[k] = sel[NumAxes + k];
      end
   end

endmodule

`default_nettype wire

// ===== design/rcfd_map.sv =====
`default_nettype none

module rcfd_map
   import rcfd_pkg::*;
#(
   parameter int AXIS_FULL_SCALE = 660
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire pick_type               in_pick,
   output logic                        in_ready,
   output logic                        out_valid,
   input  wire logic                   out_stall,
   output axis_type [NumAxes-1:0]      out_axis,
   output sw_type [NumSwitches-1:0]    out_sw
);

   localparam int FsWidth = $clog2(AXIS_FULL_SCALE + 1);
   localparam int NWide   = 10 + FsWidth + 1;
   localparam int NW      = (NWide > 21) ? NWide : 21;
   localparam logic [NW-1:0] FullScale = NW'(AXIS_FULL_SCALE);

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;
   pick_type pick0_ff;
   sw_type [NumSwitches-1:0] sw1_ff, sw1_in, sw2_ff, sw3_ff;

   // a stage loads when it is empty or its word moves on
   assign rdy3 = !v3_ff || !out_stall;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign in_ready  = rdy0;
   assign out_valid = v3_ff;
   assign out_sw    = sw3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) pick0_ff <= in_pick;
      if (rdy1) sw1_ff <= sw1_in;
      if (rdy2) sw2_ff <= sw1_ff;
      if (rdy3) sw3_ff <= sw2_ff;
   end

   always_comb begin
      for (int k = 0; k < NumSwitches; k++) begin
         if (pick0_ff.sw[k] <= SwLow) begin
            sw1_in[k] = SwDown;
         end else if (pick0_ff.sw[k] >= SwHigh) begin
            sw1_in[k] = SwUp;
         end else begin
            sw1_in[k] = SwMiddle;
         end
      end
   end

   for (genvar a = 0; a < NumAxes; a++) begin : g_axis
      chan_type        clamped;
      logic            neg1_in, neg1_ff, neg2_ff, sat2_in, sat2_ff;
      logic [9:0]      delta;
      logic [NW-1:0]   n1_in, n1_ff;
      logic [40:0]     prod2_in, prod2_ff;
      logic [10:0]     quot;
      axis_type        axis3_in, axis3_ff;

      always_comb begin
         if (pick0_ff.axis[a] < ChMin) begin
            clamped = ChMin;
         end else if (pick0_ff.axis[a] > ChMax) begin
            clamped = ChMax;
         end else begin
            clamped = pick0_ff.axis[a];
         end
         neg1_in = clamped < ChMid;
         delta   = neg1_in ? 10'(ChMid - clamped) : 10'(clamped - ChMid);
         n1_in   = NW'(delta) * FullScale + (neg1_in ? NW'(RndNeg) : NW'(RndPos));
      end

      // divide by the span through a reciprocal; saturated words take the axis limit instead
      always_comb begin
         sat2_in  = neg1_ff ? (n1_ff >= NW'(SatNeg)) : (n1_ff >= NW'(SatPos));
         prod2_in = 41'(n1_ff[19:0]) * 41'(neg1_ff ? MulNeg : MulPos);
      end

      assign quot = prod2_ff[40:30];

      always_comb begin
         if (sat2_ff) begin
            axis3_in = neg2_ff ? AxisMin : AxisMax;
         end else if (neg2_ff) begin
            axis3_in = axis_type'(~quot + 11'd1);
         end else begin
            axis3_in = axis_type'(quot);
         end
      end

      always_ff @(posedge clock) begin
         if (rdy1) begin
            n1_ff   <= n1_in;
            neg1_ff <= neg1_in;
         end
         if (rdy2) begin
            prod2_ff <= prod2_in;
            sat2_ff  <= sat2_in;
            neg2_ff  <= neg1_ff;
         end
         if (rdy3) begin
            axis3_ff <= axis3_in;
         end
      end

      assign out_axis[a] = axis3_ff;
   end

endmodule

`default_nettype wire

// ===== design/rc_link_frame_decoder_top.sv =====
// RC link frame decoder.
// req_ channel: one serial byte per word on req_rx_byte. A frame is an address
// byte, a length byte, a type byte, the payload and a CRC-8 byte. Bytes are
// parsed as they arrive, one word per cycle unless req_stall; no gaps needed.
// rsp_ channel: one word per good channel frame (type 0x16, length 24, CRC
// match): five scaled axes and two three-level switches.
// csr_ port: seven 5-bit source registers; the user writes them only while no
// frame is pending, which the block does not enforce. The result word reaches
// rsp_valid through the registers of the four-stage map pipeline (pick, scale
// multiply, reciprocal multiply, saturate). Throughput: one byte per cycle in
// while req_stall is low, one result per cycle out at most when rsp_stall is low.
// Reset: parser returns to waiting for an address byte, pipeline empties,
// sources go back to their defaults.
// When rsp_stall holds, results queue in the map pipeline; req_stall rises only
// once all four stages hold a result and rsp_stall is high.
`default_nettype none

module rc_link_frame_decoder_top
   import rcfd_pkg::*;
#(
   parameter int AXIS_FULL_SCALE  = 660,
   parameter int MAX_FRAME_LENGTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output axis_type         rsp_axis_0,
   output axis_type         rsp_axis_1,
   output axis_type         rsp_axis_2,
   output axis_type         rsp_axis_3,
   output axis_type         rsp_axis_4,
   output sw_type           rsp_switch_0,
   output sw_type           rsp_switch_1,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_data
);

   src_type [NumSrc-1:0]      source_ff;
   logic                      byte_accept;
   logic                      hit;
   logic                      map_ready;
   pick_type                  pick;
   axis_type [NumAxes-1:0]    axis;
   sw_type [NumSwitches-1:0]  sw;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= {NumSrc{SrcReset}};
      end else if (csr_write && csr_index < 3'(NumSrc)) begin
         source_ff[csr_index] <= csr_data;
      end
   end

   assign req_stall   = !map_ready;
   assign byte_accept = req_valid && !req_stall;

   rcfd_parser #(
      .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_accept(byte_accept),
      .byte_data  (req_rx_byte),
      .source     (source_ff),
      .hit        (hit),
      .pick       (pick)
   );

   rcfd_map #(
      .AXIS_FULL_SCALE(AXIS_FULL_SCALE)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .in_valid (hit),
      .in_pick  (pick),
      .in_ready (map_ready),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_axis (axis),
      .out_sw   (sw)
   );

   assign rsp_axis_0   = axis[0];
   assign rsp_axis_1   = axis[1];
   assign rsp_axis_2   = axis[2];
   assign rsp_axis_3   = axis[3];
   assign rsp_axis_4   = axis[4];
   assign rsp_switch_0 = sw[0];
   assign rsp_switch_1 = sw[1];

   // input backs up only when the whole result pipeline is full and held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a full, stalled result pipeline");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_switch_0 != 2'd3 && rsp_switch_1 != 2'd3))
      else $error("switch position out of range");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (hit && !byte_accept) |-> 1'b0)
      else $error("frame hit without an accepted word");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
   import rcfd_pkg::*;

   localparam int FullScale    = 660;
   localparam int MaxFrameLen  = 64;
   localparam int WatchLimit   = 1000;
   localparam int DrainCycles  = 8;
   localparam int RandomBytes  = 1000;
   localparam int PayloadBytes = 22;
   localparam int ChLo         = 172;
   localparam int ChCenter     = 992;
   localparam int ChHi         = 1811;
   localparam int SwDownMax    = (ChLo + ChCenter) / 2;
   localparam int SwUpMin      = (ChCenter + ChHi) / 2;
   localparam logic [7:0] RcLength = 8'd24;

   localparam int EdgeVals [15] = '{0, 171, 172, 173, 582, 583, 991, 992, 993,
                                   1400, 1401, 1810, 1811, 1812, 2047};

   typedef enum logic [2:0] {
      RegAxis0Src, RegAxis1Src, RegAxis2Src, RegAxis3Src, RegAxis4Src,
      RegSwitch0Src, RegSwitch1Src, RegUnused
   } source_reg_type;

   typedef struct packed {
      logic [NumAxes-1:0][10:0]    axis;
      logic [NumSwitches-1:0][1:0] sw;
   } rc_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   axis_type   rsp_axis_0, rsp_axis_1, rsp_axis_2, rsp_axis_3, rsp_axis_4;
   sw_type     rsp_switch_0, rsp_switch_1;
   logic       csr_write;
   logic [2:0] csr_index;
   logic [4:0] csr_data;

   // predicted parser state
   logic [6:0]  prs_pos, prs_total;
   logic [7:0]  prs_crc, prs_kind;
   logic [17:0] prs_accum;
   logic [4:0]  prs_nbits, prs_nchan;
   chan_type    prs_chan [NumChannels];
   src_type     src_reg [NumSrc];

   rc_result_type pending_results [$];
   chan_type    tx_chan [NumChannels];
   int          errors;
   int          bytes_sent;
   int          idle_cycles;
   bit          pacing_on;

   rc_link_frame_decoder_top #(
      .AXIS_FULL_SCALE (FullScale),
      .MAX_FRAME_LENGTH(MaxFrameLen)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_axis_0  (rsp_axis_0),
      .rsp_axis_1  (rsp_axis_1),
      .rsp_axis_2  (rsp_axis_2),
      .rsp_axis_3  (rsp_axis_3),
      .rsp_axis_4  (rsp_axis_4),
      .rsp_switch_0(rsp_switch_0),
      .rsp_switch_1(rsp_switch_1),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bitwise MSB-first form of the 0xD5 CRC-8
   function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
      logic [7:0] r;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         if (r[7] ^ data[i]) r = {r[6:0], 1'b0} ^ CrcPoly;
         else r = {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic int clamped(chan_type raw);
      int v;
      v = raw;
      if (v < ChLo) v = ChLo;
      else if (v > ChHi) v = ChHi;
      return v;
   endfunction

   function automatic logic [10:0] scaled_axis(chan_type raw);
      int v, r;
      v = clamped(raw);
      if (v >= ChCenter)
         r = ((v - ChCenter) * FullScale + (ChHi - ChCenter) / 2) / (ChHi - ChCenter);
      else
         r = -(((ChCenter - v) * FullScale + (ChCenter - ChLo) / 2) / (ChCenter - ChLo));
      if (r > 1023) r = 1023;
      if (r < -1024) r = -1024;
      return r[10:0];
   endfunction

   function automatic sw_type switch_level(chan_type raw);
      int v;
      v = clamped(raw);
      if (v <= SwDownMax) return SwDown;
      if (v >= SwUpMin) return SwUp;
      return SwMiddle;
   endfunction

   function automatic chan_type picked_channel(int slot);
      src_type s;
      s = src_reg[slot];
      if (s >= 5'd16) return prs_chan[DefaultChannel[slot]];
      return prs_chan[s[3:0]];
   endfunction

   function automatic chan_type rand_channel();
      if ($urandom_range(0, 3) == 0) return chan_type'(EdgeVals[$urandom_range(0, 14)]);
      return chan_type'($urandom_range(0, 2047));
   endfunction

   // advance the predicted parser by one accepted word
   task automatic decode_byte(logic [7:0] b);
      rc_result_type res;
      int         pos;
      bit         hit;
      if (prs_pos == 7'd0) begin
         prs_pos = 7'd1;
      end else if (prs_pos == 7'd1) begin
         if (b < 2 || b > MaxFrameLen) begin
            prs_pos   = 7'd0;
            prs_total = 7'd0;
         end else begin
            prs_total = b[6:0] + 7'd2;
            prs_pos   = 7'd2;
            prs_crc   = 8'h00;
            prs_accum = '0;
            prs_nbits = '0;
            prs_nchan = '0;
         end
      end else if (prs_total < 4 || prs_total > MaxFrameLen + 2) begin
         prs_pos   = 7'd0;
         prs_total = 7'd0;
      end else begin
         pos     = prs_pos;
         prs_pos = 7'(pos + 1);
         if (pos + 1 >= prs_total) begin
            hit = (b == prs_crc) && (prs_kind == KindRcPacked) &&
                  (prs_total == RcFrameTotal) && (prs_nchan >= 5'd16);
            prs_pos   = 7'd0;
            prs_total = 7'd0;
            if (hit) begin
               for (int i = 0; i < NumAxes; i++) res.axis[i] = scaled_axis(picked_channel(i));
               for (int j = 0; j < NumSwitches; j++)
                  res.sw[j] = switch_level(picked_channel(NumAxes + j));
               pending_results.push_back(res);
            end
         end else begin
            prs_crc = crc8_next(prs_crc, b);
            if (pos == 2) begin
               prs_kind = b;
            end else if (pos <= 2 + PayloadBytes) begin
               prs_accum = prs_accum | (18'(b) << prs_nbits[3:0]);
               prs_nbits = prs_nbits + 5'd8;
               if (prs_nbits >= 5'd11 && prs_nchan < 5'd16) begin
                  prs_chan[prs_nchan[3:0]] = prs_accum[10:0];
                  prs_nchan = prs_nchan + 5'd1;
                  prs_accum = prs_accum >> 11;
                  prs_nbits = prs_nbits - 5'd11;
               end
            end
         end
      end
   endtask

   // valid stays high after acceptance; the next word or settle() decides
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = pacing_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(logic [7:0] addr, logic [7:0] len, logic [7:0] kind,
                             bit from_channels, bit crc_good);
      logic [7:0]   crc, d;
      logic [175:0] bits;
      for (int c = 0; c < NumChannels; c++) bits[c*11 +: 11] = tx_chan[c];
      crc = crc8_next(8'h00, kind);
      send_byte(addr);
      send_byte(len);
      send_byte(kind);
      for (int i = 0; i < int'(len) - 2; i++) begin
         d = (from_channels && i < PayloadBytes) ? bits[i*8 +: 8] : 8'($urandom);
         crc = crc8_next(crc, d);
         send_byte(d);
      end
      send_byte(crc_good ? crc : crc ^ (8'd1 << $urandom_range(0, 7)));
   endtask

   task automatic fill_channels(bit scatter, chan_type v);
      for (int c = 0; c < NumChannels; c++) tx_chan[c] = scatter ? rand_channel() : v;
   endtask

   // finish any partial frame, drop valid and drain the map pipeline
   task automatic settle();
      while (prs_pos != 7'd0) send_byte(8'h00);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_source(source_reg_type idx, src_type val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      if (idx != RegUnused) src_reg[idx] = val;
   endtask

   task automatic configure_sources(bit scatter, src_type fixed);
      settle();
      for (int i = 0; i < NumSrc; i++)
         write_source(source_reg_type'(i), scatter ? src_type'($urandom_range(0, 31)) : fixed);
      if ($urandom_range(0, 1)) write_source(RegUnused, src_type'($urandom_range(0, 31)));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic test_default_sources();
      pacing_on = 1'b0;
      fill_channels(1'b0, 11'd172);
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      fill_channels(1'b0, 11'd1811);
      send_frame(8'h00, RcLength, KindRcPacked, 1'b1, 1'b1);
      fill_channels(1'b0, 11'd992);
      send_frame(8'hFF, RcLength, KindRcPacked, 1'b1, 1'b1);
      fill_channels(1'b0, 11'd0);
      send_frame(8'hEE, RcLength, KindRcPacked, 1'b1, 1'b1);
      fill_channels(1'b0, 11'd2047);
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      // switch thresholds and the values around the center
      fill_channels(1'b0, 11'd992);
      tx_chan[0] = 11'd991;
      tx_chan[1] = 11'd993;
      tx_chan[2] = 11'd173;
      tx_chan[3] = 11'd1810;
      tx_chan[4] = 11'd582;
      tx_chan[5] = 11'd583;
      tx_chan[6] = 11'd171;
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      tx_chan[4] = 11'd1400;
      tx_chan[5] = 11'd1401;
      tx_chan[6] = 11'd1812;
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      settle();
   endtask

   task automatic test_frame_errors();
      pacing_on = 1'b1;
      // bad length bytes: parser drops back to waiting for an address
      send_byte(8'hC8);
      send_byte(8'd0);
      send_byte(8'hC8);
      send_byte(8'd1);
      send_byte(8'hC8);
      send_byte(8'(MaxFrameLen + 1));
      send_byte(8'hC8);
      send_byte(8'hFF);
      fill_channels(1'b1, '0);
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b0);
      send_frame(8'hC8, RcLength, KindRcPacked + 8'd1, 1'b1, 1'b1);
      send_frame(8'hC8, RcLength + 8'd1, KindRcPacked, 1'b1, 1'b1);
      send_frame(8'hC8, RcLength - 8'd1, KindRcPacked, 1'b1, 1'b1);
      send_frame(8'hC8, 8'd2, KindRcPacked, 1'b1, 1'b1);
      send_frame(8'hC8, 8'(MaxFrameLen), 8'($urandom), 1'b0, 1'b1);
      send_frame(8'hC8, RcLength, KindRcPacked, 1'b1, 1'b1);
      settle();
   endtask

   task automatic test_source_select();
      src_type fixed_vals [4];
      fixed_vals = '{5'd0, 5'd15, 5'd16, 5'd31};
      pacing_on = 1'b1;
      foreach (fixed_vals[k]) begin
         configure_sources(1'b0, fixed_vals[k]);
         repeat (2) begin
            fill_channels(1'b1, '0);
            send_frame(8'($urandom), RcLength, KindRcPacked, 1'b1, 1'b1);
         end
      end
      repeat (3) begin
         configure_sources(1'b1, '0);
         repeat (2) begin
            fill_channels(1'b1, '0);
            send_frame(8'($urandom), RcLength, KindRcPacked, 1'b1, 1'b1);
         end
      end
   endtask

   task automatic test_random_traffic();
      int start_bytes, events, pick;
      start_bytes = bytes_sent;
      events = 0;
      while (bytes_sent - start_bytes < RandomBytes) begin
         if (events % 12 == 0) begin
            configure_sources($urandom_range(0, 3) != 0, src_type'($urandom_range(0, 31)));
            pacing_on = $urandom_range(0, 4) != 0;
         end
         pick = $urandom_range(0, 19);
         fill_channels(1'b1, '0);
         if (pick < 14) begin
            send_frame(8'($urandom), RcLength, KindRcPacked, 1'b1, 1'b1);
         end else if (pick == 14) begin
            send_frame(8'($urandom), RcLength, KindRcPacked, 1'b1, 1'b0);
         end else if (pick == 15) begin
            send_frame(8'($urandom), RcLength, 8'($urandom), 1'b1, 1'b1);
         end else if (pick == 16) begin
            send_frame(8'($urandom), 8'($urandom_range(2, MaxFrameLen)),
                       $urandom_range(0, 1) ? KindRcPacked : 8'($urandom),
                       1'b1, 1'($urandom_range(0, 1)));
         end else if (pick == 17) begin
            send_byte(8'($urandom));
            send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                           : 8'($urandom_range(MaxFrameLen + 1, 255)));
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
         end
         events++;
      end
   endtask

   // receiver pacing: hold stall for a random count, then take one word
   initial begin : rsp_pacer
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = pacing_on ? $urandom_range(0, 7) : 0;
         @(negedge clock);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rc_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_axis_4, rsp_axis_3, rsp_axis_2, rsp_axis_1, rsp_axis_0,
                rsp_switch_1, rsp_switch_0};
         if (pending_results.size() == 0) begin
            $display("%0t: expected no result, got axes %0d %0d %0d %0d %0d switches %0d %0d",
                     $time, rsp_axis_0, rsp_axis_1, rsp_axis_2, rsp_axis_3, rsp_axis_4,
                     rsp_switch_0, rsp_switch_1);
            errors++;
         end else begin
            want = pending_results.pop_front();
            for (int i = 0; i < NumAxes; i++)
               if (got.axis[i] !== want.axis[i]) begin
                  $display("%0t: axis_%0d expected %0d, got %0d", $time, i,
                           $signed(want.axis[i]), $signed(got.axis[i]));
                  errors++;
               end
            for (int j = 0; j < NumSwitches; j++)
               if (got.sw[j] !== want.sw[j]) begin
                  $display("%0t: switch_%0d expected %0d, got %0d", $time, j,
                           want.sw[j], got.sw[j]);
                  errors++;
               end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
         $display("rc_link_frame_decoder_top: mismatch");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = 8'h00;
      csr_write    = 1'b0;
      csr_index    = RegAxis0Src;
      csr_data     = '0;
      errors       = 0;
      bytes_sent   = 0;
      idle_cycles  = 0;
      pacing_on    = 1'b1;
      prs_pos      = '0;
      prs_total    = '0;
      prs_crc      = '0;
      prs_kind     = '0;
      prs_accum    = '0;
      prs_nbits    = '0;
      prs_nchan    = '0;
      foreach (prs_chan[c]) prs_chan[c] = '0;
      foreach (src_reg[s]) src_reg[s] = SrcReset;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_sources();
      test_frame_errors();
      test_source_select();
      test_random_traffic();
      settle();

      if (errors == 0) begin
         $display("rc_link_frame_decoder_top: match");
      end else begin
         $display("rc_link_frame_decoder_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/rcfd_pkg.sv
design/rcfd_parser.sv
design/rcfd_map.sv
design/rc_link_frame_decoder_top.sv
sim/testbench.sv
